// File: rtl/pee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPERAND = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_SUB     = 3'd2,
    CMD_MUL     = 3'd3,
    CMD_DIV     = 3'd4
  } cmd_t;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_DIVZERO  = 2'd3;

  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

  // classified token handed from the front end to the back end
  typedef struct packed {
    logic                    is_push;
    logic                    is_op;
    logic [CMD_W-1:0]        op;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } tok_t;

endpackage
`default_nettype wire

// File: rtl/pee_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pee_in_if / pee_out_if
// Valid/ready channels for tokens and results.
// ----------------------------------------------------------------------------
interface pee_in_if;
  logic                         valid;
  logic                         ready;
  logic [pee_pkg::CMD_W-1:0]    command;
  logic signed [pee_pkg::VAL_W-1:0] token_value;
  logic                         last_token;
  modport source (output valid, command, token_value, last_token, input ready);
  modport sink (input valid, command, token_value, last_token, output ready);
endinterface

interface pee_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [pee_pkg::VAL_W-1:0] result_value;
  logic [pee_pkg::ST_W-1:0]     status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

// File: rtl/pee_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pee_front
// Accepts tokens, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module pee_front (
  input  wire logic        clk,
  input  wire logic        rst,
  pee_in_if.sink           in_ch,
  output pee_pkg::tok_t    tok,
  output logic             tok_valid,
  input  wire logic        tok_pop
);

  localparam int QD = 2;

  pee_pkg::tok_t q [QD];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  pee_pkg::tok_t cls;
  logic          push;

  always_comb begin
    cls         = '0;
    cls.op      = in_ch.command;
    cls.value   = in_ch.token_value;
    cls.last    = in_ch.last_token;
    cls.is_push = (in_ch.command == pee_pkg::CMD_OPERAND);
    cls.is_op   = (in_ch.command == pee_pkg::CMD_ADD) || (in_ch.command == pee_pkg::CMD_SUB) ||
                  (in_ch.command == pee_pkg::CMD_MUL) || (in_ch.command == pee_pkg::CMD_DIV);
  end

  assign in_ch.ready = (fill != 2'(QD));
  assign push        = in_ch.valid && in_ch.ready;
  assign tok_valid   = (fill != 2'd0);
  assign tok         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (tok_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(tok_pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/pee_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pee_div
// Radix-2 restoring divider: (a << 16) / b, truncated, saturated to Q16.16.
// ----------------------------------------------------------------------------
module pee_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [pee_pkg::VAL_W-1:0] a,
  input  wire logic signed [pee_pkg::VAL_W-1:0] b,
  output logic                               done,
  output logic signed [pee_pkg::VAL_W-1:0]   q_out
);

  localparam int NW = 48;

  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [32:0]   rem;
  logic [31:0]   den;
  logic          neg;
  logic [5:0]    cnt;
  logic          busy;
  logic [32:0]   trial;
  logic [48:0]   sq;

  assign trial = {rem[31:0], num[NW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= {(a[31] ? 32'(-a) : a), 16'd0};
      den <= b[31] ? 32'(-b) : b;
      neg <= a[31] ^ b[31];
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[NW-2:0], 1'b0};
      if (!trial[32]) begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[31:0], num[NW-1]};
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sq = neg ? -{1'b0, quo} : {1'b0, quo};
    if (!sq[48] && sq[47:31] != 17'd0)      q_out = pee_pkg::Q_MAX;
    else if (sq[48] && sq[47:31] != 17'h1FFFF) q_out = pee_pkg::Q_MIN;
    else                                     q_out = sq[31:0];
  end

endmodule
`default_nettype wire

// File: rtl/pee_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pee_back
// Executes tokens on the operand stack and emits results.
// ----------------------------------------------------------------------------
module pee_back #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  pee_pkg::tok_t    tok,
  input  wire logic        tok_valid,
  output logic             tok_pop,
  pee_out_if.source        out_ch
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD1  = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_CALC = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  logic signed [31:0] mem [STACK_DEPTH];
  logic signed [31:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      count;
  logic               ovf, dz;
  pee_pkg::tok_t      cur;
  logic signed [31:0] opa, opb, res;
  logic signed [63:0] prod;
  logic               wr_en;
  logic               wr_pend;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               div_start, div_done;
  logic signed [31:0] div_q;
  logic signed [32:0] sum;
  logic signed [47:0] psh;
  logic               out_valid;
  logic signed [31:0] out_val;
  logic [1:0]         out_st;

  pee_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(opa), .b(opb),
    .done(div_done), .q_out(div_q)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign tok_pop = (state == S_IDLE) && tok_valid && !(tok.last && out_valid);
  assign out_ch.valid        = out_valid;
  assign out_ch.result_value = out_val;
  assign out_ch.status       = out_st;

  always_comb begin
    sum = (cur.op == pee_pkg::CMD_ADD) ? (33'(opa) + 33'(opb)) : (33'(opa) - 33'(opb));
    // arithmetic shift floors, matching round toward minus infinity
    psh = prod[63:16];
    res = sum[32] != sum[31] ? (sum[32] ? pee_pkg::Q_MIN : pee_pkg::Q_MAX) : sum[31:0];
  end

  always_comb begin
    rd_addr = AW'(count - CW'(1));
    if (state == S_RD1) rd_addr = AW'(count - CW'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      dz        <= 1'b0;
      out_valid <= 1'b0;
      wr_en     <= 1'b0;
      wr_pend   <= 1'b0;
      div_start <= 1'b0;
    end else begin
      wr_en     <= 1'b0;
      wr_pend   <= wr_en;
      div_start <= 1'b0;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (tok_pop) begin
            cur <= tok;
            if (tok.is_push) begin
              if (count < CW'(STACK_DEPTH)) begin
                wr_en   <= 1'b1;
                wr_addr <= AW'(count);
                wr_data <= tok.value;
                count   <= count + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
              state <= S_FIN;
            end else if (tok.is_op && count >= CW'(2)) begin
              state <= S_RD1;
            end else begin
              if (tok.is_op && count == CW'(1)) count <= '0;
              state <= S_FIN;
            end
          end
        end
        S_RD1: begin
          opb   <= rd_data;
          state <= S_RD2;
        end
        S_RD2: begin
          opa   <= rd_data;
          state <= S_CALC;
        end
        S_CALC: begin
          if (cur.op == pee_pkg::CMD_MUL) begin
            state <= S_MUL;
          end else if (cur.op == pee_pkg::CMD_DIV) begin
            if (opb == 32'sd0) begin
              state <= S_DIV;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end else begin
            state <= S_MUL;
          end
          prod <= 64'(opa) * 64'(opb);
        end
        S_MUL: begin
          wr_en   <= 1'b1;
          wr_addr <= AW'(count - CW'(2));
          count   <= count - CW'(1);
          if (cur.op == pee_pkg::CMD_MUL) begin
            if (psh > 48'sh7FFF_FFFF)       wr_data <= pee_pkg::Q_MAX;
            else if (psh < -48'sh8000_0000) wr_data <= pee_pkg::Q_MIN;
            else                            wr_data <= psh[31:0];
          end else begin
            wr_data <= res;
          end
          state <= S_FIN;
        end
        S_DIV: begin
          if (opb == 32'sd0) begin
            dz      <= 1'b1;
            wr_en   <= 1'b1;
            wr_addr <= AW'(count - CW'(2));
            count   <= count - CW'(1);
            wr_data <= opa[31] ? pee_pkg::Q_MIN : ((opa == 32'sd0) ? 32'sd0 : pee_pkg::Q_MAX);
            state   <= S_FIN;
          end else if (div_done) begin
            wr_en   <= 1'b1;
            wr_addr <= AW'(count - CW'(2));
            count   <= count - CW'(1);
            wr_data <= div_q;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          // wait until the last write has passed through the registered read
          if (!wr_en && !wr_pend) begin
            if (cur.last) begin
              out_valid <= 1'b1;
              if (count == '0) begin
                out_val <= '0;
                out_st  <= pee_pkg::ST_EMPTY;
              end else begin
                out_val <= rd_data;
                out_st  <= dz ? pee_pkg::ST_DIVZERO :
                           (ovf ? pee_pkg::ST_OVERFLOW : pee_pkg::ST_OK);
              end
              count <= '0;
              ovf   <= 1'b0;
              dz    <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/postfix_expression_evaluator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// RPN evaluator on a bounded Q16.16 operand stack.
// ----------------------------------------------------------------------------
// A push writes the stack; add, subtract, multiply and a divide by zero read
// two operands and write back; a divide uses the 48-step radix-2 divider; a
// dropped or ignored token only finishes. A two-entry queue decouples intake
// from execution; a result is held in an output register so tokens that are
// not last can be taken while it waits, and a last token waits until it drains.
module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  pee_in_if.sink   in_ch,
  pee_out_if.source out_ch
);

  pee_pkg::tok_t tok;
  logic          tok_valid;
  logic          tok_pop;

  pee_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .tok(tok), .tok_valid(tok_valid), .tok_pop(tok_pop)
  );

  pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst(rst), .tok(tok), .tok_valid(tok_valid), .tok_pop(tok_pop), .out_ch(out_ch)
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (rst) tok_pop |-> tok_valid)
    else $error("pop from empty queue");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == pee_pkg::ST_EMPTY) |-> out_ch.result_value == '0)
    else $error("empty result not zero");

endmodule
`default_nettype wire
